// File: hdl/aisp_pkg.sv
// Package for the ARM64 immediate sequence planner.
// Holds the move kind codes, chunk geometry and the plan record passed front to back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aisp_pkg;

  localparam int unsigned ImmW    = 64;
  localparam int unsigned ChunkW  = 16;
  localparam int unsigned NChunks = ImmW / ChunkW;

  typedef enum logic [1:0] {
    MOVE_MOVZ = 2'd0,
    MOVE_MOVN = 2'd1,
    MOVE_MOVK = 2'd2,
    MOVE_ORR  = 2'd3
  } move_kind_e;

  // One classified constant: either a single instruction or a MOVZ/MOVN + MOVK run
  typedef struct packed {
    logic               single;      // one instruction, taken from kind/narrow/value
    move_kind_e         kind;
    logic               narrow;
    logic               fill_ones;   // general case: fill is all-ones, opener is MOVN
    logic [NChunks-1:0] chunk_mask;  // general case: chunks that differ from the fill
    logic [ImmW-1:0]    value;       // single operand, or the constant itself
  } plan_t;

endpackage

`default_nettype wire

// File: hdl/aisp_if.sv
// Valid/ready channel interfaces for the planner: constant in, instruction out.
// Depends on aisp_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface aisp_in_if;
  logic                       valid;
  logic                       ready;
  logic [aisp_pkg::ImmW-1:0]  imm_value;

  modport source (output valid, output imm_value, input ready);
  modport sink   (input valid, input imm_value, output ready);
endinterface

interface aisp_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 move_kind;
  logic                       narrow_dest;
  logic [aisp_pkg::ImmW-1:0]  operand_value;
  logic                       last_move;

  modport source (output valid, output move_kind, output narrow_dest,
                  output operand_value, output last_move, input ready);
  modport sink   (input valid, input move_kind, input narrow_dest,
                  input operand_value, input last_move, output ready);
endinterface

`default_nettype wire

// File: hdl/aisp_front.sv
// Front end: takes constant beats into an input register and classifies them into plans.
// Depends on aisp_pkg and aisp_in_if.
`timescale 1ns / 1ps
`default_nettype none

module aisp_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  aisp_in_if.sink              in_i,
  input  wire logic            q_full_i,
  output aisp_pkg::plan_t      plan_o,
  output logic                 push_o
);
  import aisp_pkg::*;

  logic            valid_q, valid_d;
  logic [ImmW-1:0] imm_q;

  // At most one aligned chunk is nonzero
  function automatic logic one_chunk(input logic [ImmW-1:0] v);
    logic [NChunks-1:0] nz;
    for (int n = 0; n < NChunks; n++) begin
      nz[n] = v[n*ChunkW +: ChunkW] != '0;
    end
    return (nz & (nz - NChunks'(1))) == '0;
  endfunction

  // Logical immediate test: find the repeating element, then require exactly two
  // bit transitions around it. Zero and all-ones give no transitions.
  function automatic logic logical_imm(input logic [ImmW-1:0] v, input logic is32);
    logic [63:0] diff;
    logic [63:0] d1;
    logic [31:0] x32;
    logic [15:0] x16;
    logic [7:0]  x8;
    logic [3:0]  x4;
    logic [1:0]  x2;
    x32 = v[31:0];
    x16 = v[15:0];
    x8  = v[7:0];
    x4  = v[3:0];
    x2  = v[1:0];
    priority if (!is32 && (v[31:0] != v[63:32])) begin
      diff = v ^ {v[0], v[63:1]};
    end else if (v[15:0] != v[31:16]) begin
      diff = {32'd0, x32 ^ {x32[0], x32[31:1]}};
    end else if (v[7:0] != v[15:8]) begin
      diff = {48'd0, x16 ^ {x16[0], x16[15:1]}};
    end else if (v[3:0] != v[7:4]) begin
      diff = {56'd0, x8 ^ {x8[0], x8[7:1]}};
    end else if (v[1:0] != v[3:2]) begin
      diff = {60'd0, x4 ^ {x4[0], x4[3:1]}};
    end else begin
      diff = {62'd0, x2 ^ {x2[0], x2[1]}};
    end
    d1 = diff & (diff - 64'd1);
    return (d1 != '0) && ((d1 & (d1 - 64'd1)) == '0);
  endfunction

  // Input register: a new beat is taken when it is empty or the held one moves on
  assign push_o    = valid_q && !q_full_i;
  assign in_i.ready = !valid_q || !q_full_i;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      imm_q <= in_i.imm_value;
    end
  end

  // Classification, rules tried in order
  always_comb begin
    logic [ImmW-1:0]  inv;
    logic             upper_zero;
    logic [2:0]       zeros;
    logic [2:0]       ones;
    logic [ChunkW-1:0] c;
    logic             fill;
    inv        = ~imm_q;
    upper_zero = imm_q[63:32] == '0;
    zeros      = '0;
    ones       = '0;
    for (int n = 0; n < NChunks; n++) begin
      c = imm_q[n*ChunkW +: ChunkW];
      zeros = zeros + 3'(c == '0);
      ones  = ones + 3'(c == '1);
    end
    fill = ones > zeros;

    plan_o.single    = 1'b1;
    plan_o.kind      = MOVE_MOVZ;
    plan_o.narrow    = 1'b0;
    plan_o.fill_ones = fill;
    plan_o.value     = imm_q;
    for (int n = 0; n < NChunks; n++) begin
      plan_o.chunk_mask[n] = imm_q[n*ChunkW +: ChunkW] != {ChunkW{fill}};
    end

    priority if (one_chunk(imm_q)) begin
      plan_o.kind = MOVE_MOVZ;
    end else if (one_chunk(inv)) begin
      plan_o.kind  = MOVE_MOVN;
      plan_o.value = inv;
    end else if (upper_zero && (imm_q[31:16] == '1 || imm_q[15:0] == '1)) begin
      plan_o.kind   = MOVE_MOVN;
      plan_o.narrow = 1'b1;
      plan_o.value  = {32'd0, inv[31:0]};
    end else if (upper_zero && logical_imm(imm_q, 1'b1)) begin
      plan_o.kind   = MOVE_ORR;
      plan_o.narrow = 1'b1;
    end else if (logical_imm(imm_q, 1'b0)) begin
      plan_o.kind = MOVE_ORR;
    end else begin
      plan_o.single = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: hdl/aisp_queue.sv
// Short plan queue between the front and back ends.
// Depends on aisp_pkg for the plan record.
`timescale 1ns / 1ps
`default_nettype none

module aisp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  aisp_pkg::plan_t       plan_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output aisp_pkg::plan_t       head_o,
  output logic                  head_valid_o
);
  import aisp_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  plan_t             entry_q [DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o       = cnt_q == CntW'(DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = entry_q[rd_q];

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= plan_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/aisp_back.sv
// Back end: walks the head plan, one instruction beat per cycle while out_o is ready.
// Depends on aisp_pkg and aisp_out_if.
`timescale 1ns / 1ps
`default_nettype none

module aisp_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  aisp_pkg::plan_t       head_i,
  input  wire logic             head_valid_i,
  output logic                  pop_o,
  aisp_out_if.source            out_o
);
  import aisp_pkg::*;

  logic               busy_q, busy_d;        // a general plan is part way through
  logic [NChunks-1:0] rem_q, rem_d;
  logic               out_valid_q, out_valid_d;
  move_kind_e         kind_q, kind_d;
  logic               narrow_q, narrow_d;
  logic [ImmW-1:0]    operand_q, operand_d;
  logic               last_q, last_d;
  logic               load;

  // Output register frees up when empty or taken this cycle
  assign load = !out_valid_q || out_o.ready;

  always_comb begin
    logic [NChunks-1:0] rem;
    logic [NChunks-1:0] rem_next;
    logic [1:0]         pos;
    logic [ChunkW-1:0]  chunk;
    logic               first;
    rem         = busy_q ? rem_q : head_i.chunk_mask;
    first       = !busy_q;
    busy_d      = busy_q;
    rem_d       = rem_q;
    pop_o       = 1'b0;
    out_valid_d = load ? 1'b0 : out_valid_q;
    kind_d      = kind_q;
    narrow_d    = narrow_q;
    operand_d   = operand_q;
    last_d      = last_q;

    // Lowest chunk still to be written
    priority if (rem[0]) begin
      pos = 2'd0;
    end else if (rem[1]) begin
      pos = 2'd1;
    end else if (rem[2]) begin
      pos = 2'd2;
    end else begin
      pos = 2'd3;
    end
    rem_next = rem & ~(NChunks'(1) << pos);
    chunk    = head_i.value[{pos, 4'b0} +: ChunkW];

    if (head_valid_i && load) begin
      if (head_i.single) begin
        out_valid_d = 1'b1;
        kind_d      = head_i.kind;
        narrow_d    = head_i.narrow;
        operand_d   = head_i.value;
        last_d      = 1'b1;
        pop_o       = 1'b1;
      end else if (rem == '0) begin
        // nothing to emit: drop the plan
        pop_o  = 1'b1;
        busy_d = 1'b0;
      end else begin
        out_valid_d = 1'b1;
        narrow_d    = 1'b0;
        operand_d   = '0;
        operand_d[{pos, 4'b0} +: ChunkW] =
          chunk ^ {ChunkW{first && head_i.fill_ones}};
        if (!first) begin
          kind_d = MOVE_MOVK;
        end else if (head_i.fill_ones) begin
          kind_d = MOVE_MOVN;
        end else begin
          kind_d = MOVE_MOVZ;
        end
        last_d = rem_next == '0;
        if (rem_next == '0) begin
          pop_o  = 1'b1;
          busy_d = 1'b0;
        end else begin
          busy_d = 1'b1;
          rem_d  = rem_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    narrow_q  <= narrow_d;
    operand_q <= operand_d;
    last_q    <= last_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.move_kind     = kind_q;
  assign out_o.narrow_dest   = narrow_q;
  assign out_o.operand_value = operand_q;
  assign out_o.last_move     = last_q;

endmodule

`default_nettype wire

// File: hdl/arm64_immediate_sequence_planner_unit.sv
// Top level of the ARM64 immediate sequence planner: front end, plan queue, back end.
// Depends on aisp_pkg, aisp_if, aisp_front, aisp_queue and aisp_back.
`timescale 1ns / 1ps
`default_nettype none

// Each 64-bit constant beat on in_i yields one to four instruction beats on out_o, the
// final one flagged by last_move. Constants that fit a single MOVZ, MOVN or ORR give one
// beat; otherwise a MOVZ or MOVN opener is followed by a MOVK for each further chunk that
// differs from the fill. The back end emits one instruction per clock while out_o is not
// stalled, so a constant with more instructions occupies it longer; that output sequencer
// sets the sustained rate. The front end classifies a constant combinationally from its
// input register and runs ahead into a QUEUE_DEPTH-entry plan queue (at least 2), so input
// beats keep flowing while a long sequence or a stalled output drains, until the queue
// fills. A constant passes the front input register, the queue and the output register.
module arm64_immediate_sequence_planner_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  aisp_in_if.sink     in_i,
  aisp_out_if.source  out_o
);
  import aisp_pkg::*;

  plan_t front_plan;
  plan_t head_plan;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_head_valid;

  aisp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .plan_o   (front_plan),
    .push_o   (q_push)
  );

  aisp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .plan_i       (front_plan),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_o       (head_plan),
    .head_valid_o (q_head_valid)
  );

  aisp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_plan),
    .head_valid_i (q_head_valid),
    .pop_o        (q_pop),
    .out_o        (out_o)
  );

  // The front never writes a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("plan pushed into full queue");

  // The back only retires a plan that is there
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_head_valid)
    else $error("plan popped from empty queue");

  // ORR and narrow moves are always single-instruction sequences
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.move_kind == MOVE_ORR || out_o.narrow_dest) |-> out_o.last_move)
    else $error("ORR or narrow move not marked last");

endmodule

`default_nettype wire

// File: test/aisp_move_checker.sv
// Scoreboard for the ARM64 immediate sequence planner: predicts each constant's move plan.
// Watches both channels, compares every instruction beat field by field, counts mismatches.
// Depends on aisp_pkg for the move kind codes and widths.
`timescale 1ns / 1ps

module aisp_move_checker (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic                     in_ready_i,
  input  wire logic [aisp_pkg::ImmW-1:0] in_imm_i,
  input  wire logic                     out_valid_i,
  input  wire logic                     out_ready_i,
  input  wire logic [1:0]               out_kind_i,
  input  wire logic                     out_narrow_i,
  input  wire logic [aisp_pkg::ImmW-1:0] out_operand_i,
  input  wire logic                     out_last_i,
  output int                            mismatch_count_o,
  output int                            pending_count_o,
  output int                            constants_seen_o,
  output int                            moves_seen_o,
  output int                            multi_move_plans_o
);
  import aisp_pkg::*;

  typedef struct {
    move_kind_e      kind;
    bit              narrow;
    logic [ImmW-1:0] operand;
    bit              last;
  } planned_move_t;

  planned_move_t expected_moves[$];

  initial begin
    mismatch_count_o   = 0;
    pending_count_o    = 0;
    constants_seen_o   = 0;
    moves_seen_o       = 0;
    multi_move_plans_o = 0;
  end

  // Nonzero in at most one aligned 16-bit chunk (zero counts)
  function automatic bit fits_one_chunk(logic [63:0] v);
    return (v & 64'h0000_0000_0000_ffff) == v || (v & 64'h0000_0000_ffff_0000) == v ||
           (v & 64'h0000_ffff_0000_0000) == v || (v & 64'hffff_0000_0000_0000) == v;
  endfunction

  // Bitmask immediate test: shrink to the smallest repeating element, then the
  // element must be a rotated run of ones, i.e. exactly two bit transitions.
  function automatic bit is_bitmask_imm(logic [63:0] v, int unsigned size);
    logic [63:0] mask;
    logic [63:0] hmask;
    logic [63:0] emask;
    logic [63:0] part;
    logic [63:0] x;
    logic [63:0] rot;
    int unsigned esz;
    int unsigned half;
    mask = (size >= 64) ? '1 : (64'd1 << size) - 64'd1;
    v    = v & mask;
    if (v == 64'd0 || v == mask) return 1'b0;
    esz = size;
    while (esz > 2) begin
      half  = esz / 2;
      hmask = (64'd1 << half) - 64'd1;
      emask = (esz >= 64) ? '1 : (64'd1 << esz) - 64'd1;
      part  = v & emask;
      if ((part & hmask) != ((part >> half) & hmask)) break;
      esz = half;
    end
    mask = (esz >= 64) ? '1 : (64'd1 << esz) - 64'd1;
    x    = v & mask;
    if (x == 64'd0 || x == mask) return 1'b0;
    rot = ((x >> 1) | (x << (esz - 1))) & mask;
    return $countones(x ^ rot) == 2;
  endfunction

  // Work out the instruction sequence for one constant and queue it
  function automatic void plan_constant(logic [63:0] v);
    planned_move_t plan[$];
    planned_move_t mv;
    logic [63:0]   inv;
    logic [63:0]   inv32;
    logic [15:0]   chunk;
    logic [15:0]   fill;
    logic [15:0]   flip;
    move_kind_e    opener;
    bit            upper_zero;
    int            zeros;
    int            ones;
    inv        = ~v;
    inv32      = inv & 64'h0000_0000_ffff_ffff;
    upper_zero = (v[63:32] == 32'd0);
    mv.last    = 1'b1;
    mv.narrow  = 1'b0;
    if (fits_one_chunk(v)) begin
      mv.kind = MOVE_MOVZ; mv.operand = v;
      plan.push_back(mv);
    end else if (fits_one_chunk(inv)) begin
      mv.kind = MOVE_MOVN; mv.operand = inv;
      plan.push_back(mv);
    end else if (upper_zero && ((inv32 & 64'hffff) == inv32 ||
                                (inv32 & 64'hffff_0000) == inv32)) begin
      mv.kind = MOVE_MOVN; mv.narrow = 1'b1; mv.operand = inv32;
      plan.push_back(mv);
    end else if (upper_zero && is_bitmask_imm(v, 32)) begin
      mv.kind = MOVE_ORR; mv.narrow = 1'b1; mv.operand = v;
      plan.push_back(mv);
    end else if (is_bitmask_imm(v, 64)) begin
      mv.kind = MOVE_ORR; mv.operand = v;
      plan.push_back(mv);
    end else begin
      // general case: opener plus MOVKs for chunks that differ from the fill
      zeros = 0;
      ones  = 0;
      for (int n = 0; n < NChunks; n++) begin
        chunk = v[16*n +: 16];
        if (chunk == 16'h0000) zeros++;
        else if (chunk == 16'hffff) ones++;
      end
      fill   = (ones > zeros) ? 16'hffff : 16'h0000;
      flip   = fill;
      opener = (ones > zeros) ? MOVE_MOVN : MOVE_MOVZ;
      mv.last = 1'b0;
      for (int n = 0; n < NChunks; n++) begin
        chunk = v[16*n +: 16];
        if (chunk != fill) begin
          mv.kind    = opener;
          mv.operand = {48'd0, chunk ^ flip} << (16 * n);
          plan.push_back(mv);
          opener = MOVE_MOVK;
          flip   = 16'h0000;
        end
      end
      plan[plan.size()-1].last = 1'b1;
    end
    if (plan.size() > 1) multi_move_plans_o++;
    foreach (plan[i]) expected_moves.push_back(plan[i]);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count_o < 50) $display("[%0t] mismatch: %s", $time, what);
    mismatch_count_o++;
  endtask

  // Results first, then new constants: a beat cannot stem from a same-edge input
  always @(posedge clk_i) begin
    planned_move_t exp_mv;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        moves_seen_o++;
        if (expected_moves.size() == 0) begin
          report_mismatch($sformatf("unexpected beat kind %0d operand %h",
                                    out_kind_i, out_operand_i));
        end else begin
          exp_mv = expected_moves.pop_front();
          if (out_kind_i !== exp_mv.kind)
            report_mismatch($sformatf("move_kind %0d, expected %s",
                                      out_kind_i, exp_mv.kind.name()));
          if (out_narrow_i !== exp_mv.narrow)
            report_mismatch($sformatf("narrow_dest %b, expected %b",
                                      out_narrow_i, exp_mv.narrow));
          if (out_operand_i !== exp_mv.operand)
            report_mismatch($sformatf("operand_value %h, expected %h",
                                      out_operand_i, exp_mv.operand));
          if (out_last_i !== exp_mv.last)
            report_mismatch($sformatf("last_move %b, expected %b",
                                      out_last_i, exp_mv.last));
        end
      end
      if (in_valid_i && in_ready_i) begin
        constants_seen_o++;
        plan_constant(in_imm_i);
      end
      pending_count_o = expected_moves.size();
    end
  end

endmodule

// File: test/tb.sv
// Top of the planner testbench: clock, reset, constant stimulus and the verdict.
// Depends on aisp_pkg, aisp_if, the planner top level and aisp_move_checker.
`timescale 1ns / 1ps

module tb;

  localparam int CycleLimit   = 200000;
  localparam int PhaseItems   = 75;
  localparam int DrainCycles  = 20;
  localparam int NumDirected  = 25;

  logic clk_i;
  logic rst_ni;

  aisp_in_if  in_ch ();
  aisp_out_if out_ch ();

  int mismatch_count;
  int pending_count;
  int constants_seen;
  int moves_seen;
  int multi_move_plans;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;

  // Extremes, each rule, MOVN narrow with zero operand, fill tie-break
  logic [63:0] directed_values [NumDirected] = '{
    64'h0000_0000_0000_0000, 64'h0000_0000_0000_ffff, 64'hffff_0000_0000_0000,
    64'h0000_1234_0000_0000, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_1234,
    64'hffff_5678_ffff_ffff, 64'hfffe_ffff_ffff_ffff, 64'h0000_0000_ffff_1234,
    64'h0000_0000_1234_ffff, 64'h0000_0000_ffff_ffff, 64'h0000_0000_5555_5555,
    64'h0000_0000_0ff0_0ff0, 64'h0000_0000_8000_0001, 64'h5555_5555_5555_5555,
    64'h00ff_00ff_00ff_00ff, 64'h0000_ffff_ffff_0000, 64'h7fff_ffff_ffff_fffe,
    64'h8000_0000_0000_0001, 64'h0000_0000_1234_5678, 64'h1234_5678_9abc_def0,
    64'hffff_ffff_1234_5678, 64'h1234_ffff_ffff_5678, 64'hffff_0000_1234_5678,
    64'h0001_0000_0000_8000
  };

  arm64_immediate_sequence_planner_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  aisp_move_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_ch.valid),
    .in_ready_i         (in_ch.ready),
    .in_imm_i           (in_ch.imm_value),
    .out_valid_i        (out_ch.valid),
    .out_ready_i        (out_ch.ready),
    .out_kind_i         (out_ch.move_kind),
    .out_narrow_i       (out_ch.narrow_dest),
    .out_operand_i      (out_ch.operand_value),
    .out_last_i         (out_ch.last_move),
    .mismatch_count_o   (mismatch_count),
    .pending_count_o    (pending_count),
    .constants_seen_o   (constants_seen),
    .moves_seen_o       (moves_seen),
    .multi_move_plans_o (multi_move_plans)
  );

  // 12 ns clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Output back-pressure
  always @(negedge clk_i) begin
    out_ch.ready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d moves still expected", cycle_count, pending_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Bitmask immediate: rotated run of ones in an element, replicated across the width
  function automatic logic [63:0] make_bitmask(bit narrow);
    logic [63:0] elem;
    logic [63:0] emask;
    logic [63:0] word;
    int unsigned esz;
    int unsigned run;
    int unsigned rot;
    int unsigned total;
    total = narrow ? 32 : 64;
    esz   = 2 << $urandom_range(0, narrow ? 4 : 5);
    run   = $urandom_range(1, esz - 1);
    rot   = $urandom_range(0, esz - 1);
    emask = (esz >= 64) ? '1 : (64'd1 << esz) - 64'd1;
    elem  = (64'd1 << run) - 64'd1;
    if (rot != 0) elem = ((elem >> rot) | (elem << (esz - rot))) & emask;
    word = 64'd0;
    for (int unsigned i = 0; i < total; i += esz) word |= elem << i;
    return word;
  endfunction

  // Mix of constants aimed at every planning rule
  function automatic logic [63:0] random_constant();
    logic [63:0] word;
    logic [15:0] chunk;
    int unsigned pos;
    word  = {$urandom, $urandom};
    chunk = 16'($urandom_range(0, 16'hffff));
    pos   = $urandom_range(0, 3);
    case ($urandom_range(0, 9))
      2: word = {48'd0, chunk} << (16 * pos);
      3: word = ~({48'd0, chunk} << (16 * pos));
      4: word = pos[0] ? {32'd0, chunk, 16'hffff} : {32'd0, 16'hffff, chunk};
      5: word = make_bitmask(1'b1);
      6: word = make_bitmask(1'b0);
      7, 8, 9: begin
        for (int n = 0; n < 4; n++) begin
          case ($urandom_range(0, 2))
            0:       word[16*n +: 16] = 16'h0000;
            1:       word[16*n +: 16] = 16'hffff;
            default: word[16*n +: 16] = 16'($urandom_range(0, 16'hffff));
          endcase
        end
      end
      default: ;
    endcase
    return word;
  endfunction

  // Drive one constant beat; returns at the falling edge after acceptance
  task automatic send_constant(input logic [63:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.imm_value <= value;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold the input off until every planned move has come out
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.imm_value = '0;
    out_ch.ready    = 1'b0;
    rst_ni          = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_values[i]) send_constant(directed_values[i]);
    hold_until_drained();

    // idling phases: none, sender idle, receiver stalling, both lightly
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
      endcase
      repeat (PhaseItems) send_constant(random_constant());
      hold_until_drained();
    end

    recv_stall_pct = 0;
    repeat (DrainCycles) @(negedge clk_i);

    $display("Planned %0d constants (%0d directed) into %0d moves; %0d needed a MOVK run.",
             constants_seen, NumDirected, moves_seen, multi_move_plans);
    $display("Idling phases covered: none, sender 70%%, receiver 70%%, both 6%%.");
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
